// File: rtl/rie_pkg.sv
package rie_pkg;

  // one request word and one result word
  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  caller_pid;
    logic [1:0]  peer_kind;
    logic [4:0]  peer_pid;
    logic [31:0] msg_handle;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        copy_valid;
    logic [31:0] copy_from_handle;
    logic [31:0] copy_to_handle;
    logic [4:0]  source_pid;
    logic        irq_msg;
    logic        wake_valid;
    logic [4:0]  wake_pid;
  } res_t;

  localparam logic [1:0] OP_SEND   = 2'd0;
  localparam logic [1:0] OP_RECV   = 2'd1;
  localparam logic [1:0] OP_NOTIFY = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  localparam logic [1:0] PK_PID = 2'd0;
  localparam logic [1:0] PK_ANY = 2'd1;
  localparam logic [1:0] PK_INT = 2'd2;
  localparam logic [1:0] PK_BAD = 2'd3;

  localparam logic [1:0] AW_NONE = 2'd0;
  localparam logic [1:0] AW_PID  = 2'd1;
  localparam logic [1:0] AW_ANY  = 2'd2;
  localparam logic [1:0] AW_INT  = 2'd3;

  localparam logic [3:0] ST_SENT     = 4'd0;
  localparam logic [3:0] ST_QUEUED   = 4'd1;
  localparam logic [3:0] ST_TAKEN    = 4'd2;
  localparam logic [3:0] ST_INT_RCVD = 4'd3;
  localparam logic [3:0] ST_WAITS    = 4'd4;
  localparam logic [3:0] ST_INT_DLVR = 4'd5;
  localparam logic [3:0] ST_INT_REC  = 4'd6;
  localparam logic [3:0] ST_DEADLOCK = 4'd7;
  localparam logic [3:0] ST_INVALID  = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_INT_CHK, S_WK_ISSUE, S_WK_STEP, S_SND_CHK, S_AP_HEADW,
    S_AP_ISSUE, S_AP_STEP, S_RC_TGTW, S_RM_HEADW, S_RM_ISSUE, S_RM_STEP, S_RM_FIN
  } state_t;

  // table read address select
  typedef enum logic [2:0] {
    RA_CALLER, RA_PEER, RA_P, RA_CUR, RA_S
  } ra_t;

  // datapath action chosen by the controller
  typedef enum logic [4:0] {
    A_NOP, A_LATCH, A_INVALID, A_INT_DLVR, A_INT_REC, A_WK_INIT, A_WK_ADV,
    A_DEADLOCK, A_SEND_DLVR, A_SEND_QUEUE, A_AP_INIT, A_AP_ADV, A_AP_LINK,
    A_RCV_INT, A_RCV_WAIT, A_RM_INIT, A_RM_ADV, A_RM_LINK, A_RM_FIN
  } act_t;

  typedef struct packed {
    act_t act;
    ra_t  ra;
  } cmd_t;

  typedef struct packed {
    logic       pid_bad;
    logic [1:0] op;
    logic [1:0] kind;
    logic       caller_busy;
    logic       caller_rcv;
    logic       caller_ipend;
    logic       caller_qhv;
    logic       send_bad;
    logic       recv_bad;
    logic       peer_live;
    logic       p_sending;
    logic       cnt_max;
    logic       tgt_hit;
    logic       int_match;
    logic       snd_match;
    logic       peer_qhv;
    logic       qn_more;
    logic       cur_valid;
    logic       cur_is_s;
    logic       rc_tgt_ok;
  } stat_t;

endpackage

// File: rtl/rie_ctrl.sv
module rie_ctrl
  import rie_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_IDLE;
        if (st.pid_bad) begin
          state_next = S_IDLE;
        end else if (st.op == OP_NOTIFY) begin
          if (st.caller_rcv) state_next = S_INT_CHK;
        end else if (st.caller_busy) begin
          state_next = S_IDLE;
        end else if (st.op == OP_SEND) begin
          if (!st.send_bad) state_next = S_WK_ISSUE;
        end else if (!st.recv_bad && !(st.caller_ipend && st.kind != PK_PID)) begin
          if (st.kind == PK_ANY && st.caller_qhv) state_next = S_RM_HEADW;
          if (st.kind == PK_PID && st.peer_live) state_next = S_RC_TGTW;
        end
      end
      S_INT_CHK: state_next = S_IDLE;
      S_WK_ISSUE: state_next = (st.cnt_max || !st.p_sending) ? S_SND_CHK : S_WK_STEP;
      S_WK_STEP: state_next = st.tgt_hit ? S_IDLE : S_WK_ISSUE;
      S_SND_CHK: state_next = (!st.snd_match && st.peer_qhv) ? S_AP_HEADW : S_IDLE;
      S_AP_HEADW: state_next = S_AP_ISSUE;
      S_AP_ISSUE: state_next = S_AP_STEP;
      S_AP_STEP: state_next = (st.qn_more && !st.cnt_max) ? S_AP_ISSUE : S_IDLE;
      S_RC_TGTW: state_next = st.rc_tgt_ok ? S_RM_HEADW : S_IDLE;
      S_RM_HEADW: state_next = S_RM_ISSUE;
      S_RM_ISSUE: state_next = (!st.cur_valid || st.cnt_max) ? S_IDLE : S_RM_STEP;
      S_RM_STEP: state_next = st.cur_is_s ? S_RM_FIN : S_RM_ISSUE;
      S_RM_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd.act = A_NOP;
    cmd.ra  = RA_CALLER;
    case (state)
      S_IDLE: begin
        if (start) cmd.act = A_LATCH;
      end
      S_DEC: begin
        if (st.op == OP_RECV && st.kind == PK_PID) cmd.ra = RA_PEER;
        if (st.pid_bad) begin
          cmd.act = A_INVALID;
        end else if (st.op == OP_NOTIFY) begin
          if (!st.caller_rcv) cmd.act = A_INT_REC;
        end else if (st.caller_busy) begin
          cmd.act = A_INVALID;
        end else if (st.op == OP_SEND) begin
          cmd.act = st.send_bad ? A_INVALID : A_WK_INIT;
        end else if (st.recv_bad) begin
          cmd.act = A_INVALID;
        end else if (st.caller_ipend && st.kind != PK_PID) begin
          cmd.act = A_RCV_INT;
        end else if (st.kind == PK_ANY) begin
          if (!st.caller_qhv) cmd.act = A_RCV_WAIT;
        end else if (st.kind == PK_PID) begin
          if (!st.peer_live) cmd.act = A_RCV_WAIT;
        end else begin
          cmd.act = A_RCV_WAIT;
        end
      end
      S_INT_CHK: cmd.act = st.int_match ? A_INT_DLVR : A_INT_REC;
      S_WK_ISSUE: cmd.ra = (st.cnt_max || !st.p_sending) ? RA_PEER : RA_P;
      S_WK_STEP: cmd.act = st.tgt_hit ? A_DEADLOCK : A_WK_ADV;
      S_SND_CHK: begin
        cmd.ra  = RA_PEER;
        cmd.act = st.snd_match ? A_SEND_DLVR : A_SEND_QUEUE;
      end
      S_AP_HEADW: cmd.act = A_AP_INIT;
      S_AP_ISSUE: cmd.ra = RA_P;
      S_AP_STEP: cmd.act = (st.qn_more && !st.cnt_max) ? A_AP_ADV : A_AP_LINK;
      S_RC_TGTW: cmd.act = st.rc_tgt_ok ? A_NOP : A_RCV_WAIT;
      S_RM_HEADW: cmd.act = A_RM_INIT;
      S_RM_ISSUE: begin
        cmd.ra = RA_CUR;
        if (!st.cur_valid || st.cnt_max) cmd.act = A_RCV_WAIT;
      end
      S_RM_STEP: begin
        cmd.ra  = RA_S;
        cmd.act = st.cur_is_s ? A_RM_LINK : A_RM_ADV;
      end
      S_RM_FIN: cmd.act = A_RM_FIN;
      default: cmd.act = A_NOP;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/rie_dp.sv
module rie_dp
  import rie_pkg::*;
#(
  parameter int MAX_PROCS   = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  cmd_t       cmd,
  output stat_t      st,
  output logic       done,
  output res_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  localparam int PW = $clog2(MAX_PROCS);
  localparam int IW = (PW > 5) ? PW : 5;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

  req_t            rq;
  logic [5:0]      live;
  logic [IW-1:0]   caller_x, peer_x;
  logic [PW-1:0]   ci, pi;
  logic [HW-1:0]   h;
  logic            peer_oob;

  // per-process flags
  logic [MAX_PROCS-1:0] snd, rcv, ipend, qhv;

  // walk registers
  logic [PW-1:0] p, cur, prev, s;
  logic [CW-1:0] cnt;
  logic          cur_valid, has_prev;

  // tables
  logic [PW-1:0] tgt_mem [MAX_PROCS];
  logic [PW+1:0] awk_mem [MAX_PROCS];
  logic [HW-1:0] buf_mem [MAX_PROCS];
  logic [PW-1:0] qh_mem  [MAX_PROCS];
  logic [PW:0]   qn_mem  [MAX_PROCS];

  logic [PW-1:0] tgt_q, qh_q;
  logic [PW+1:0] awk_q;
  logic [HW-1:0] buf_q;
  logic [PW:0]   qn_q;
  logic [PW-1:0] ra_addr;

  logic          tgt_we, awk_we, buf_we, qh_we, qn_we;
  logic [PW-1:0] tgt_wa, awk_wa, buf_wa, qh_wa, qn_wa;
  logic [PW-1:0] tgt_wd, qh_wd;
  logic [PW+1:0] awk_wd;
  logic [HW-1:0] buf_wd;
  logic [PW:0]   qn_wd;
  logic [1:0]    aw_code;

  logic          term;
  res_t          res_next;

  assign caller_x  = IW'(rq.caller_pid);
  assign peer_x    = IW'(rq.peer_pid);
  assign ci        = caller_x[PW-1:0];
  assign pi        = peer_x[PW-1:0];
  assign h         = HW'(rq.msg_handle);
  assign peer_oob  = (32'(rq.peer_pid) >= MAX_PROCS);
  assign cfg_ready = 1'b1;

  // status toward the controller
  always_comb begin
    st.pid_bad      = (32'(rq.caller_pid) >= MAX_PROCS) || (rq.opcode == OP_BAD);
    st.op           = rq.opcode;
    st.kind         = rq.peer_kind;
    st.caller_busy  = snd[ci] | rcv[ci];
    st.caller_rcv   = rcv[ci];
    st.caller_ipend = ipend[ci];
    st.caller_qhv   = qhv[ci];
    st.send_bad     = (rq.peer_kind != PK_PID) || (rq.peer_pid == rq.caller_pid) || peer_oob;
    st.recv_bad     = (rq.peer_kind == PK_BAD) ||
                      ((rq.peer_kind == PK_PID) && ((rq.peer_pid == rq.caller_pid) || peer_oob));
    st.peer_live    = ({1'b0, rq.peer_pid} < live);
    st.p_sending    = snd[p];
    st.cnt_max      = (cnt == CW'(MAX_PROCS));
    st.tgt_hit      = (tgt_q == ci);
    st.int_match    = (awk_q[PW+1:PW] == AW_ANY) || (awk_q[PW+1:PW] == AW_INT);
    st.snd_match    = rcv[pi] && ((awk_q[PW+1:PW] == AW_ANY) ||
                      ((awk_q[PW+1:PW] == AW_PID) && (awk_q[PW-1:0] == ci)));
    st.peer_qhv     = qhv[pi];
    st.qn_more      = qn_q[PW];
    st.cur_valid    = cur_valid;
    st.cur_is_s     = (cur == s);
    st.rc_tgt_ok    = snd[pi] && (tgt_q == ci);
  end

  // read address
  always_comb begin
    case (cmd.ra)
      RA_CALLER: ra_addr = ci;
      RA_PEER:   ra_addr = pi;
      RA_P:      ra_addr = p;
      RA_CUR:    ra_addr = cur;
      RA_S:      ra_addr = s;
      default:   ra_addr = ci;
    endcase
  end

  always_comb begin
    case (rq.peer_kind)
      PK_PID:  aw_code = AW_PID;
      PK_ANY:  aw_code = AW_ANY;
      default: aw_code = AW_INT;
    endcase
  end

  // table writes
  always_comb begin
    tgt_we = 1'b0; tgt_wa = ci; tgt_wd = pi;
    buf_we = 1'b0; buf_wa = ci; buf_wd = h;
    awk_we = 1'b0; awk_wa = ci;
    awk_wd = {aw_code, (rq.peer_kind == PK_PID) ? pi : {PW{1'b0}}};
    qh_we  = 1'b0; qh_wa  = pi; qh_wd  = ci;
    qn_we  = 1'b0; qn_wa  = ci; qn_wd  = '0;
    case (cmd.act)
      A_SEND_QUEUE: begin
        tgt_we = 1'b1;
        buf_we = 1'b1;
        qn_we  = 1'b1;
        qh_we  = !qhv[pi];
      end
      A_RCV_WAIT: begin
        buf_we = 1'b1;
        awk_we = 1'b1;
      end
      A_AP_LINK: begin
        qn_we = 1'b1;
        qn_wa = p;
        qn_wd = {1'b1, ci};
      end
      A_RM_LINK: begin
        if (has_prev) begin
          qn_we = 1'b1;
          qn_wa = prev;
          qn_wd = qn_q;
        end else begin
          qh_we = 1'b1;
          qh_wa = ci;
          qh_wd = qn_q[PW-1:0];
        end
      end
      A_RM_FIN: begin
        qn_we = 1'b1;
        qn_wa = s;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    if (awk_we) awk_mem[awk_wa] <= awk_wd;
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    if (qh_we)  qh_mem[qh_wa]   <= qh_wd;
    if (qn_we)  qn_mem[qn_wa]   <= qn_wd;
    tgt_q <= tgt_mem[ra_addr];
    awk_q <= awk_mem[ra_addr];
    buf_q <= buf_mem[ra_addr];
    qh_q  <= qh_mem[ra_addr];
    qn_q  <= qn_mem[ra_addr];
  end

  // flags, config and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      snd   <= '0;
      rcv   <= '0;
      ipend <= '0;
      qhv   <= '0;
      live  <= '0;
      done  <= 1'b0;
    end else begin
      done <= term;
      if (cfg_valid) live <= cfg_data;
      case (cmd.act)
        A_INT_DLVR: begin
          rcv[ci]   <= 1'b0;
          ipend[ci] <= 1'b0;
        end
        A_INT_REC:   ipend[ci] <= 1'b1;
        A_SEND_DLVR: rcv[pi] <= 1'b0;
        A_SEND_QUEUE: begin
          snd[ci] <= 1'b1;
          qhv[pi] <= 1'b1;
        end
        A_RCV_INT:  ipend[ci] <= 1'b0;
        A_RCV_WAIT: rcv[ci] <= 1'b1;
        A_RM_LINK: begin
          if (!has_prev) qhv[ci] <= qn_q[PW];
        end
        A_RM_FIN: snd[s] <= 1'b0;
        default: ;
      endcase
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      A_LATCH: rq <= req;
      A_WK_INIT: begin
        p   <= pi;
        cnt <= '0;
      end
      A_WK_ADV: begin
        p   <= tgt_q;
        cnt <= cnt + CW'(1);
      end
      A_AP_INIT: begin
        p   <= qh_q;
        cnt <= '0;
      end
      A_AP_ADV: begin
        p   <= qn_q[PW-1:0];
        cnt <= cnt + CW'(1);
      end
      A_RM_INIT: begin
        cur       <= qh_q;
        cur_valid <= qhv[ci];
        s         <= (rq.peer_kind == PK_ANY) ? qh_q : pi;
        has_prev  <= 1'b0;
        cnt       <= '0;
      end
      A_RM_ADV: begin
        prev      <= cur;
        has_prev  <= 1'b1;
        cur       <= qn_q[PW-1:0];
        cur_valid <= qn_q[PW];
        cnt       <= cnt + CW'(1);
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    res_next = '0;
    term     = 1'b1;
    case (cmd.act)
      A_INVALID:  res_next.status = ST_INVALID;
      A_INT_REC:  res_next.status = ST_INT_REC;
      A_DEADLOCK: res_next.status = ST_DEADLOCK;
      A_RCV_WAIT: res_next.status = ST_WAITS;
      A_AP_LINK:  res_next.status = ST_QUEUED;
      A_SEND_QUEUE: begin
        res_next.status = ST_QUEUED;
        term            = !qhv[pi];
      end
      A_INT_DLVR: begin
        res_next.status         = ST_INT_DLVR;
        res_next.copy_valid     = 1'b1;
        res_next.copy_to_handle = 32'(buf_q);
        res_next.irq_msg        = 1'b1;
        res_next.wake_valid     = 1'b1;
        res_next.wake_pid       = rq.caller_pid;
      end
      A_SEND_DLVR: begin
        res_next.status           = ST_SENT;
        res_next.copy_valid       = 1'b1;
        res_next.copy_from_handle = 32'(h);
        res_next.copy_to_handle   = 32'(buf_q);
        res_next.source_pid       = rq.caller_pid;
        res_next.wake_valid       = 1'b1;
        res_next.wake_pid         = rq.peer_pid;
      end
      A_RCV_INT: begin
        res_next.status         = ST_INT_RCVD;
        res_next.copy_valid     = 1'b1;
        res_next.copy_to_handle = 32'(h);
        res_next.irq_msg        = 1'b1;
      end
      A_RM_FIN: begin
        res_next.status           = ST_TAKEN;
        res_next.copy_valid       = 1'b1;
        res_next.copy_from_handle = 32'(buf_q);
        res_next.copy_to_handle   = 32'(h);
        res_next.source_pid       = 5'(s);
        res_next.wake_valid       = 1'b1;
        res_next.wake_pid         = 5'(s);
      end
      default: term = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (term) result <= res_next;
  end

`ifndef SYNTH
  // a process never blocks as sender and receiver at once
  a_not_both: assert property (@(posedge clk) disable iff (rst) (snd & rcv) == '0)
    else $error("process both sending and receiving");
  // only defined status codes leave the block
  a_res_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_INVALID))
    else $error("undefined status code");
  // an interrupt message is a copy with no source buffer
  a_irq_copy: assert property (@(posedge clk) disable iff (rst)
    (done && result.irq_msg) |-> (result.copy_valid && (result.copy_from_handle == '0)))
    else $error("interrupt message without proper copy");
`endif

endmodule

// File: rtl/rendezvous_ipc_engine.sv
// Simple requests need no walk; a send walks the deadlock chain and the receiver's
// sender queue, and a receive that unlinks a named sender walks the receiver's queue.
// Each walk step is one registered table read, in an issue state and a step state.
// One request at a time; a new one is taken the cycle done is high.
// Reset clears all process flags, queue-head valid bits and the live process count.
// done pulses one cycle with the result word; the receiver cannot stall.
module rendezvous_ipc_engine
  import rie_pkg::*;
#(
  parameter int MAX_PROCS   = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output res_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  rie_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  rie_dp #(
    .MAX_PROCS   (MAX_PROCS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_take_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not start work");
  a_one_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results in a row");
`endif

endmodule

// File: test/tb_rendezvous_ipc_engine.sv
module tb_rendezvous_ipc_engine;
  import rie_pkg::*;

  localparam int NPROC = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 4 * NPROC + 60;

  // mirror of the process table; predicts one result word per request word
  class ipc_scoreboard;
    bit         snd[NPROC];
    bit         rcv[NPROC];
    bit         ipend[NPROC];
    logic [4:0] tgt[NPROC];
    logic [1:0] awk[NPROC];
    logic [4:0] awp[NPROC];
    logic [31:0] buf_h[NPROC];
    bit         head_v[NPROC];
    logic [4:0] head[NPROC];
    bit         nxt_v[NPROC];
    logic [4:0] nxt[NPROC];
    logic [5:0] live;
    res_t       expq[$];
    int         errors;
    int         seen;
    int         by_status[16];

    function void clear();
      foreach (snd[i]) begin
        snd[i] = 0; rcv[i] = 0; ipend[i] = 0; tgt[i] = '0; awk[i] = AW_NONE;
        awp[i] = '0; buf_h[i] = '0; head_v[i] = 0; head[i] = '0;
        nxt_v[i] = 0; nxt[i] = '0;
      end
      live = '0;
    endfunction

    // follow blocked senders from dest; hit when the chain returns to caller
    function bit send_cycle(logic [4:0] c, logic [4:0] d);
      logic [4:0] q;
      q = d;
      for (int i = 0; i < NPROC; i++) begin
        if (!snd[q]) return 0;
        if (tgt[q] == c) return 1;
        q = tgt[q];
      end
      return 0;
    endfunction

    function void enqueue_sender(logic [4:0] r, logic [4:0] s);
      logic [4:0] q;
      nxt_v[s] = 0;
      nxt[s] = '0;
      if (!head_v[r]) begin
        head_v[r] = 1;
        head[r] = s;
      end else begin
        q = head[r];
        for (int i = 0; i < NPROC && nxt_v[q]; i++) q = nxt[q];
        nxt_v[q] = 1;
        nxt[q] = s;
      end
    endfunction

    function bit unlink_sender(logic [4:0] r, logic [4:0] s);
      bit cv;
      bit has_prev;
      logic [4:0] cur;
      logic [4:0] prev;
      cv = head_v[r];
      cur = head[r];
      has_prev = 0;
      prev = '0;
      for (int i = 0; i < NPROC && cv; i++) begin
        if (cur == s) begin
          if (has_prev) begin
            nxt_v[prev] = nxt_v[s];
            nxt[prev] = nxt[s];
          end else begin
            head_v[r] = nxt_v[s];
            head[r] = nxt[s];
          end
          nxt_v[s] = 0;
          nxt[s] = '0;
          return 1;
        end
        prev = cur;
        has_prev = 1;
        cv = nxt_v[cur];
        cur = nxt[cur];
      end
      return 0;
    endfunction

    function void note_request(req_t r);
      res_t e;
      logic [4:0] c, p, s;
      logic [1:0] k;
      bit ok;
      e = '0;
      e.status = ST_INVALID;
      c = r.caller_pid;
      p = r.peer_pid;
      k = r.peer_kind;
      s = '0;
      ok = 0;
      if (r.opcode == OP_BAD) begin
        e.status = ST_INVALID;
      end else if (r.opcode == OP_NOTIFY) begin
        if (rcv[c] && (awk[c] == AW_ANY || awk[c] == AW_INT)) begin
          e.copy_valid = 1; e.copy_to_handle = buf_h[c]; e.irq_msg = 1;
          e.wake_valid = 1; e.wake_pid = c;
          rcv[c] = 0; awk[c] = AW_NONE; ipend[c] = 0;
          e.status = ST_INT_DLVR;
        end else begin
          ipend[c] = 1;
          e.status = ST_INT_REC;
        end
      end else if (snd[c] || rcv[c]) begin
        e.status = ST_INVALID;
      end else if (r.opcode == OP_SEND) begin
        if (k != PK_PID || p == c) begin
          e.status = ST_INVALID;
        end else if (send_cycle(c, p)) begin
          e.status = ST_DEADLOCK;
        end else if (rcv[p] && (awk[p] == AW_ANY || (awk[p] == AW_PID && awp[p] == c))) begin
          e.copy_valid = 1; e.copy_from_handle = r.msg_handle;
          e.copy_to_handle = buf_h[p]; e.source_pid = c;
          e.wake_valid = 1; e.wake_pid = p;
          rcv[p] = 0; awk[p] = AW_NONE;
          e.status = ST_SENT;
        end else begin
          snd[c] = 1; tgt[c] = p; buf_h[c] = r.msg_handle;
          enqueue_sender(p, c);
          e.status = ST_QUEUED;
        end
      end else begin
        if (k == PK_BAD || (k == PK_PID && p == c)) begin
          e.status = ST_INVALID;
        end else if (ipend[c] && k != PK_PID) begin
          e.copy_valid = 1; e.copy_to_handle = r.msg_handle; e.irq_msg = 1;
          ipend[c] = 0;
          e.status = ST_INT_RCVD;
        end else begin
          if (k == PK_ANY) begin
            if (head_v[c]) begin
              s = head[c];
              ok = unlink_sender(c, s);
            end
          end else if (k == PK_PID && {1'b0, p} < live) begin
            if (snd[p] && tgt[p] == c) begin
              s = p;
              ok = unlink_sender(c, s);
            end
          end
          if (ok) begin
            e.copy_valid = 1; e.copy_from_handle = buf_h[s];
            e.copy_to_handle = r.msg_handle; e.source_pid = s;
            e.wake_valid = 1; e.wake_pid = s;
            snd[s] = 0;
            e.status = ST_TAKEN;
          end else begin
            rcv[c] = 1;
            awk[c] = (k == PK_PID) ? AW_PID : ((k == PK_ANY) ? AW_ANY : AW_INT);
            awp[c] = (k == PK_PID) ? p : '0;
            buf_h[c] = r.msg_handle;
            e.status = ST_WAITS;
          end
        end
      end
      expq.push_back(e);
    endfunction

    function void report(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, a);
        errors++;
        return;
      end
      e = expq.pop_front();
      seen++;
      by_status[e.status]++;
      report("status", e.status, a.status);
      report("copy_valid", e.copy_valid, a.copy_valid);
      report("copy_from_handle", e.copy_from_handle, a.copy_from_handle);
      report("copy_to_handle", e.copy_to_handle, a.copy_to_handle);
      report("source_pid", e.source_pid, a.source_pid);
      report("irq_msg", e.irq_msg, a.irq_msg);
      report("wake_valid", e.wake_valid, a.wake_valid);
      report("wake_pid", e.wake_pid, a.wake_pid);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       done;
  res_t       result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] cfg_data;

  ipc_scoreboard sb = new();
  int cycles = 0;
  int accepted = 0;
  int settings = 0;
  bit idle_on = 1'b1;

  rendezvous_ipc_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // check results, then note accepted words and register writes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) begin
        sb.note_request(req);
        accepted++;
      end
      if (cfg_valid && cfg_ready) sb.live = cfg_data;
    end
  end

  // called at a falling edge with start low; busy is stable there
  task automatic put_word(req_t r);
    if (idle_on && $urandom_range(0, 99) < 24) begin
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    while (busy) @(negedge clk);
    start <= 1'b1;
    req <= r;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_live(logic [5:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic req_t mk(logic [1:0] op, logic [4:0] c, logic [1:0] k,
                              logic [4:0] p, logic [31:0] h);
    req_t r;
    r.opcode = op; r.caller_pid = c; r.peer_kind = k; r.peer_pid = p; r.msg_handle = h;
    return r;
  endfunction

  // mostly a small set of busy processes so that queues and chains build up
  function automatic logic [4:0] pick_pid();
    return ($urandom_range(0, 99) < 75) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic req_t rand_word();
    req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.caller_pid = pick_pid();
    r.peer_pid = pick_pid();
    r.msg_handle = $urandom;
    if (sel < 40) begin
      r.opcode = OP_SEND;
      r.peer_kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : PK_PID;
    end else if (sel < 75) begin
      r.opcode = OP_RECV;
      r.peer_kind = ($urandom_range(0, 19) == 0) ? PK_BAD : 2'($urandom_range(0, 2));
    end else if (sel < 95) begin
      r.opcode = OP_NOTIFY;
      r.peer_kind = 2'($urandom_range(0, 3));
    end else begin
      r.opcode = OP_BAD;
      r.peer_kind = 2'($urandom_range(0, 3));
    end
    return r;
  endfunction

  initial begin
    logic [5:0] phase_live[5];
    sb.clear();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_live(6'd32);

    // directed: each status and each rejected form
    idle_on = 1'b0;
    put_word(mk(OP_BAD, 5'd0, PK_PID, 5'd1, 32'h0));
    put_word(mk(OP_NOTIFY, 5'd3, PK_PID, 5'd0, 32'h0));
    put_word(mk(OP_RECV, 5'd3, PK_PID, 5'd4, 32'h1234_5678));
    put_word(mk(OP_SEND, 5'd4, PK_PID, 5'd3, 32'hFFFF_FFFF));
    put_word(mk(OP_RECV, 5'd3, PK_ANY, 5'd0, 32'hA5A5_0000));
    put_word(mk(OP_SEND, 5'd5, PK_PID, 5'd5, 32'h1));
    put_word(mk(OP_SEND, 5'd5, PK_ANY, 5'd6, 32'h2));
    put_word(mk(OP_SEND, 5'd5, PK_BAD, 5'd6, 32'h2));
    put_word(mk(OP_RECV, 5'd5, PK_BAD, 5'd6, 32'h3));
    put_word(mk(OP_RECV, 5'd5, PK_PID, 5'd5, 32'h4));
    put_word(mk(OP_SEND, 5'd31, PK_PID, 5'd30, 32'h0));
    put_word(mk(OP_SEND, 5'd31, PK_PID, 5'd29, 32'h5));
    put_word(mk(OP_SEND, 5'd30, PK_PID, 5'd31, 32'h6));
    put_word(mk(OP_SEND, 5'd29, PK_PID, 5'd30, 32'h7777_7777));
    put_word(mk(OP_RECV, 5'd30, PK_ANY, 5'd0, 32'h8888_8888));
    put_word(mk(OP_RECV, 5'd30, PK_PID, 5'd29, 32'h9999_9999));
    put_word(mk(OP_RECV, 5'd6, PK_INT, 5'd0, 32'hCAFE_0006));
    put_word(mk(OP_NOTIFY, 5'd6, PK_PID, 5'd0, 32'h0));
    put_word(mk(OP_RECV, 5'd7, PK_ANY, 5'd0, 32'h0000_0007));
    put_word(mk(OP_SEND, 5'd8, PK_PID, 5'd7, 32'h8000_0000));
    put_word(mk(OP_RECV, 5'd9, PK_PID, 5'd31, 32'h9));
    drain();

    // random phases, each under a process count written before it
    phase_live[0] = 6'd0;
    phase_live[1] = 6'd32;
    phase_live[2] = 6'd1;
    phase_live[3] = 6'd17;
    phase_live[4] = 6'd32;
    for (int ph = 0; ph < 5; ph++) begin
      write_live(phase_live[ph]);
      for (int n = 0; n < 226; n++) begin
        idle_on = !(ph == 3 && n >= 40 && n < 200);
        put_word(rand_word());
      end
      drain();
    end

    $display("covered %0d request words and %0d results over %0d process counts",
             accepted, sb.seen, settings);
    $display("sent %0d queued %0d taken %0d deadlocks %0d invalid %0d irq delivered %0d",
             sb.by_status[ST_SENT], sb.by_status[ST_QUEUED], sb.by_status[ST_TAKEN],
             sb.by_status[ST_DEADLOCK], sb.by_status[ST_INVALID], sb.by_status[ST_INT_DLVR]);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
